@@ rtl/core/lpg_pkg.sv @@
// Shared types and constants of the line pixel generator.
package lpg_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COLOR_BITS     = 16;

  // Item kind carried on the slave-side tuser bit.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Step direction of one axis.
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

endpackage

@@ rtl/core/line_pixel_generator.sv @@
// Error-accumulator line rasterizer with stream input and pixel output.

// A start beat (tuser = 0) loads both endpoints and the color and produces no
// pixel; each advance beat (tuser = 1) while a line is active produces one pixel,
// major_dist + 2 pixels in all, the start point twice and the end point last
// with tlast set. An advance while idle is taken and dropped, and a start while
// active abandons the current line. The setup or the two error add-and-compare
// steps sit between the input handshake and the output register, so one beat
// is accepted in every cycle that the output register is empty or being
// drained, and the first pixel shows in the cycle after its advance beat.
module line_pixel_generator
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x_start, y_start, x_end, y_end, line_color, zero fill
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 2;
  localparam int OUT_W = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

  // Line state
  logic                  line_active;
  logic [CB-1:0]         cur_col, cur_row;
  logic [EB-1:0]         col_error, row_error;
  logic [CB-1:0]         abs_dx, abs_dy, major_dist;
  dir_t                  col_dir, row_dir;
  logic [CB:0]           pixels_left;
  logic [COLOR_BITS-1:0] held_color;

  // Output register
  logic                  out_valid;
  logic [CB-1:0]         out_x, out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  logic                  in_beat;
  logic [CB-1:0]         xs, ys, xe, ye;
  logic [COLOR_BITS-1:0] in_color;
  logic [CB-1:0]         dx_new, dy_new, major_new;
  dir_t                  col_dir_new, row_dir_new;
  logic [EB-1:0]         col_sum, row_sum;
  logic [CB:0]           pixels_left_next;
  logic [EB-1:0]         col_error_next, row_error_next;
  logic [CB-1:0]         cur_col_next, cur_row_next;
  logic                  emit;

  function automatic logic [CB-1:0] axis_move(input logic [CB-1:0] pos, input dir_t dir);
    logic [CB-1:0] res;
    case (dir)
      DIR_PLUS:  res = pos + CB'(1);
      DIR_MINUS: res = pos - CB'(1);
      default:   res = pos;
    endcase
    return res;
  endfunction

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign xs       = s_axis_tdata[CB-1:0];
  assign ys       = s_axis_tdata[2*CB-1:CB];
  assign xe       = s_axis_tdata[3*CB-1:2*CB];
  assign ye       = s_axis_tdata[4*CB-1:3*CB];
  assign in_color = s_axis_tdata[4*CB+COLOR_BITS-1:4*CB];

  // Start setup: direction and magnitude per axis
  always_comb begin
    if (xe > xs) begin
      dx_new      = xe - xs;
      col_dir_new = DIR_PLUS;
    end else if (xe < xs) begin
      dx_new      = xs - xe;
      col_dir_new = DIR_MINUS;
    end else begin
      dx_new      = '0;
      col_dir_new = DIR_NONE;
    end
    if (ye > ys) begin
      dy_new      = ye - ys;
      row_dir_new = DIR_PLUS;
    end else if (ye < ys) begin
      dy_new      = ys - ye;
      row_dir_new = DIR_MINUS;
    end else begin
      dy_new      = '0;
      row_dir_new = DIR_NONE;
    end
    major_new = (dx_new > dy_new) ? dx_new : dy_new;
  end

  // Advance step: accumulate errors and step the position
  always_comb begin
    pixels_left_next = pixels_left - (CB+1)'(1);
    col_sum          = col_error + EB'(abs_dx);
    row_sum          = row_error + EB'(abs_dy);
    col_error_next   = col_sum;
    row_error_next   = row_sum;
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    if (col_sum > EB'(major_dist)) begin
      col_error_next = col_sum - EB'(major_dist);
      cur_col_next   = axis_move(cur_col, col_dir);
    end
    if (row_sum > EB'(major_dist)) begin
      row_error_next = row_sum - EB'(major_dist);
      cur_row_next   = axis_move(cur_row, row_dir);
    end
  end

  assign emit = in_beat && (s_axis_tuser[0] == OP_ADVANCE) && line_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      cur_col     <= '0;
      cur_row     <= '0;
      col_error   <= '0;
      row_error   <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      major_dist  <= '0;
      col_dir     <= DIR_NONE;
      row_dir     <= DIR_NONE;
      pixels_left <= '0;
      held_color  <= '0;
    end else if (in_beat && (s_axis_tuser[0] == OP_START)) begin
      line_active <= 1'b1;
      cur_col     <= xs;
      cur_row     <= ys;
      col_error   <= '0;
      row_error   <= '0;
      abs_dx      <= dx_new;
      abs_dy      <= dy_new;
      major_dist  <= major_new;
      col_dir     <= col_dir_new;
      row_dir     <= row_dir_new;
      pixels_left <= {1'b0, major_new} + (CB+1)'(2);
      held_color  <= in_color;
    end else if (emit) begin
      pixels_left <= pixels_left_next;
      col_error   <= col_error_next;
      row_error   <= row_error_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      if (pixels_left_next == '0) begin
        line_active <= 1'b0;
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= cur_col;
      out_y     <= cur_row;
      out_color <= held_color;
      out_last  <= (pixels_left_next == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = OUT_W'({out_color, out_y, out_x});

  a_advance_emits: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_axis_tvalid)
    else $error("advance on an active line gave no pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    emit && (pixels_left == (CB+1)'(1)) |=> !line_active && m_axis_tlast)
    else $error("final pixel did not end the line");

  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (pixels_left != '0))
    else $error("active line with no pixels left");

  a_error_bounded: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (col_error <= EB'(major_dist)) && (row_error <= EB'(major_dist)))
    else $error("error sum above major distance");

endmodule
